// File: src/vot_pkg.sv
// ----------------------------------------------------------------------------
// vot_pkg: shared types and constants for the value occurrence table
// Operation and status codes, cell and chain control, sequencer states.
// ----------------------------------------------------------------------------
package vot_pkg;

  localparam int DEF_DEPTH = 16;
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 16;
  localparam int POS_W     = 5;
  localparam int ENTRIES_W = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SUM    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_INCR,
    CELL_SHIFT
  } cell_cmd_t;

  typedef enum logic [1:0] {
    CH_HOLD,
    CH_INSERT,
    CH_REMOVE,
    CH_ROTATE
  } chain_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } cell_data_t;

  typedef struct packed {
    chain_cmd_t         cmd;
    logic [VALUE_W-1:0] key;
    logic [POS_W-1:0]   position;
  } chain_ctrl_t;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] rm_count;
    cell_data_t         head;
  } chain_stat_t;

endpackage

// File: src/vot_if.sv
// ----------------------------------------------------------------------------
// vot_if: handshake channels of the value occurrence table
// Input channel carries commands, output channel carries results.
// ----------------------------------------------------------------------------
interface vot_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] value;
  logic [4:0]  position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink   (input valid, input operation, input value, input position,
                  output ready);
endinterface

interface vot_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  entries;
  logic [15:0] occurrences;
  logic [31:0] total;

  modport source (output valid, output status, output entries, output occurrences,
                  output total, input ready);
  modport sink   (input valid, input status, input entries, input occurrences,
                  input total, output ready);
endinterface

// File: src/vot_cell.sv
// ----------------------------------------------------------------------------
// vot_cell: one table entry
// Holds a value and its count; loads, increments or takes its neighbor.
// ----------------------------------------------------------------------------
module vot_cell (
  input  logic                       clk,
  input  vot_pkg::cell_cmd_t         cmd,
  input  logic [vot_pkg::VALUE_W-1:0] key,
  input  vot_pkg::cell_data_t        nbr,
  output vot_pkg::cell_data_t        data,
  output logic                       match
);

  vot_pkg::cell_data_t data_r;
  vot_pkg::cell_data_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd)
      vot_pkg::CELL_HOLD: data_nxt = data_r;
      vot_pkg::CELL_LOAD: begin
        data_nxt.value = key;
        data_nxt.count = vot_pkg::COUNT_W'(1);
      end
      vot_pkg::CELL_INCR: begin
        if (data_r.count != vot_pkg::COUNT_MAX) begin
          data_nxt.count = data_r.count + vot_pkg::COUNT_W'(1);
        end
      end
      vot_pkg::CELL_SHIFT: data_nxt = nbr;
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = (data_r.value == key);

endmodule

// File: src/vot_chain.sv
// ----------------------------------------------------------------------------
// vot_chain: ring of entry cells
// Decodes table commands into per-cell commands; cell i's neighbor is cell i+1.
// ----------------------------------------------------------------------------
module vot_chain #(
  parameter int DEPTH = vot_pkg::DEF_DEPTH,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  vot_pkg::chain_ctrl_t ctrl,
  input  logic [CNT_W-1:0]     total,
  output vot_pkg::chain_stat_t stat
);

  localparam int CMP_W = (CNT_W > vot_pkg::POS_W) ? CNT_W : vot_pkg::POS_W;

  vot_pkg::cell_cmd_t  cell_cmd  [DEPTH];
  vot_pkg::cell_data_t cell_data [DEPTH];
  logic [DEPTH-1:0]    cell_match;
  logic [DEPTH-1:0]    cell_hit;
  logic [CMP_W-1:0]    pos_ext;
  logic                hit;
  logic [vot_pkg::COUNT_W-1:0] hit_count;
  logic [vot_pkg::COUNT_W-1:0] hit_raw;
  logic [vot_pkg::COUNT_W-1:0] rm_count;

  assign pos_ext = CMP_W'(ctrl.position);

  always_comb begin
    hit_raw  = '0;
    rm_count = '0;
    for (int i = 0; i < DEPTH; i++) begin
      cell_hit[i] = cell_match[i] && (CNT_W'(i) < total);
      if (cell_hit[i]) begin
        hit_raw = hit_raw | cell_data[i].count;
      end
      if (CMP_W'(i + 1) == pos_ext) begin
        rm_count = rm_count | cell_data[i].count;
      end
    end
    hit = |cell_hit;
    hit_count = (hit_raw == vot_pkg::COUNT_MAX) ? hit_raw
                                                 : hit_raw + vot_pkg::COUNT_W'(1);
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_cmd[i] = vot_pkg::CELL_HOLD;
      unique case (ctrl.cmd)
        vot_pkg::CH_HOLD: cell_cmd[i] = vot_pkg::CELL_HOLD;
        vot_pkg::CH_INSERT: begin
          if (hit) begin
            if (cell_hit[i]) cell_cmd[i] = vot_pkg::CELL_INCR;
          end else if (CNT_W'(i) == total) begin
            cell_cmd[i] = vot_pkg::CELL_LOAD;
          end
        end
        // entries at and after the removed slot move up by one
        vot_pkg::CH_REMOVE: begin
          if (CMP_W'(i + 1) >= pos_ext) cell_cmd[i] = vot_pkg::CELL_SHIFT;
        end
        vot_pkg::CH_ROTATE: cell_cmd[i] = vot_pkg::CELL_SHIFT;
        default: cell_cmd[i] = vot_pkg::CELL_HOLD;
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    vot_cell u_cell (
      .clk   (clk),
      .cmd   (cell_cmd[g]),
      .key   (ctrl.key),
      .nbr   (cell_data[(g + 1) % DEPTH]),
      .data  (cell_data[g]),
      .match (cell_match[g])
    );
  end

  assign stat.hit       = hit;
  assign stat.hit_count = hit_count;
  assign stat.rm_count  = rm_count;
  assign stat.head      = cell_data[0];

endmodule

// File: src/value_occurrence_table.sv
// ----------------------------------------------------------------------------
// value_occurrence_table: ordered table of distinct values with counts
// Insert, remove by position and weighted sum over a ring of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : command transactions (operation, value, position), valid/ready.
//   out_ch : one result transaction per command (status, entries,
//            occurrences, total), valid/ready.
//   Insert, remove and the unused operation code finish in the cycle they
//   are accepted; the result is registered and valid in the next cycle.
//   Sum rotates the whole cell ring once through a 32x16 multiplier and an
//   accumulator, then passes the drain and done states before the result
//   register is loaded. The ring length sets the length of the scan.
//   Insert and remove sustain one command per cycle while out_ch is ready;
//   after a sum the next command is taken once the sequencer is idle again.
//   One command is in flight at a time; a new one is taken once the result
//   register is empty or being read in the same cycle.
//   Reset empties the table (entry count zero) and drops any pending
//   result; cell contents are not cleared and are never read before written.
//   A stall on out_ch holds the result and blocks in_ch until it is taken.
// ----------------------------------------------------------------------------
module value_occurrence_table #(
  parameter int DEPTH = vot_pkg::DEF_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  vot_in_if.sink    in_ch,
  vot_out_if.source out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = (CNT_W > vot_pkg::POS_W) ? CNT_W : vot_pkg::POS_W;

  vot_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic [vot_pkg::VALUE_W-1:0] prod_r, prod_nxt;
  logic prod_en_r, prod_en_nxt;
  logic [vot_pkg::VALUE_W-1:0] acc_r, acc_nxt;

  logic                          out_valid_r, out_valid_nxt;
  vot_pkg::status_t              out_status_r, out_status_nxt;
  logic [vot_pkg::ENTRIES_W-1:0] out_entries_r, out_entries_nxt;
  logic [vot_pkg::COUNT_W-1:0]   out_occ_r, out_occ_nxt;
  logic [vot_pkg::VALUE_W-1:0]   out_total_r, out_total_nxt;

  vot_pkg::chain_ctrl_t ctrl;
  vot_pkg::chain_stat_t stat;
  vot_pkg::op_t op;
  logic accept;
  logic out_free;
  logic pos_ok;
  logic full;
  logic scan_last;
  logic [vot_pkg::VALUE_W+vot_pkg::COUNT_W-1:0] prod_full;

  assign op        = vot_pkg::op_t'(in_ch.operation);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == vot_pkg::S_IDLE) && out_free;
  assign accept    = in_ch.valid && in_ch.ready;
  assign pos_ok    = (in_ch.position != '0) &&
                     (CMP_W'(in_ch.position) <= CMP_W'(total_r));
  assign full      = (total_r == CNT_W'(DEPTH));
  assign scan_last = (scan_r == IDX_W'(DEPTH - 1));
  assign prod_full = stat.head.value * stat.head.count;

  vot_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .total (total_r),
    .stat  (stat)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vot_pkg::S_IDLE:  if (accept && op == vot_pkg::OP_SUM) state_nxt = vot_pkg::S_SCAN;
      vot_pkg::S_SCAN:  if (scan_last) state_nxt = vot_pkg::S_DRAIN;
      vot_pkg::S_DRAIN: state_nxt = vot_pkg::S_DONE;
      vot_pkg::S_DONE:  if (out_free) state_nxt = vot_pkg::S_IDLE;
      default:          state_nxt = vot_pkg::S_IDLE;
    endcase
  end

  // datapath and result register
  always_comb begin
    ctrl.cmd      = vot_pkg::CH_HOLD;
    ctrl.key      = in_ch.value;
    ctrl.position = in_ch.position;
    total_nxt     = total_r;
    scan_nxt      = scan_r;
    prod_nxt      = prod_r;
    prod_en_nxt   = prod_en_r;
    acc_nxt       = acc_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_entries_nxt = out_entries_r;
    out_occ_nxt     = out_occ_r;
    out_total_nxt   = out_total_r;

    unique case (state_r)
      vot_pkg::S_IDLE: begin
        if (accept) begin
          out_status_nxt = vot_pkg::ST_OK;
          out_occ_nxt    = '0;
          out_total_nxt  = '0;
          unique case (op)
            vot_pkg::OP_INSERT: begin
              ctrl.cmd = vot_pkg::CH_INSERT;
              if (stat.hit) begin
                out_occ_nxt = stat.hit_count;
              end else if (full) begin
                out_status_nxt = vot_pkg::ST_FULL;
              end else begin
                total_nxt   = total_r + CNT_W'(1);
                out_occ_nxt = vot_pkg::COUNT_W'(1);
              end
            end
            vot_pkg::OP_REMOVE: begin
              if (pos_ok) begin
                ctrl.cmd    = vot_pkg::CH_REMOVE;
                total_nxt   = total_r - CNT_W'(1);
                out_occ_nxt = stat.rm_count;
              end else begin
                out_status_nxt = vot_pkg::ST_BADPOS;
              end
            end
            vot_pkg::OP_SUM: begin
              scan_nxt    = '0;
              prod_en_nxt = 1'b0;
              acc_nxt     = '0;
            end
            vot_pkg::OP_NONE: ;
            default: ;
          endcase
          out_valid_nxt   = (op != vot_pkg::OP_SUM);
          out_entries_nxt = vot_pkg::ENTRIES_W'(total_nxt);
        end
      end
      vot_pkg::S_SCAN: begin
        // cell 0 presents entry scan_r; its product is registered in prod_r and added on the next cycle
        ctrl.cmd    = vot_pkg::CH_ROTATE;
        prod_nxt    = vot_pkg::VALUE_W'(prod_full);
        prod_en_nxt = (CNT_W'(scan_r) < total_r);
        acc_nxt     = acc_r + (prod_en_r ? prod_r : '0);
        scan_nxt    = scan_r + IDX_W'(1);
      end
      vot_pkg::S_DRAIN: begin
        acc_nxt = acc_r + (prod_en_r ? prod_r : '0);
      end
      vot_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = vot_pkg::ST_OK;
          out_entries_nxt = vot_pkg::ENTRIES_W'(total_r);
          out_occ_nxt     = '0;
          out_total_nxt   = acc_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vot_pkg::S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      prod_en_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      prod_en_r   <= prod_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r        <= scan_nxt;
    prod_r        <= prod_nxt;
    acc_r         <= acc_nxt;
    out_status_r  <= out_status_nxt;
    out_entries_r <= out_entries_nxt;
    out_occ_r     <= out_occ_nxt;
    out_total_r   <= out_total_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entries     = out_entries_r;
  assign out_ch.occurrences = out_occ_r;
  assign out_ch.total       = out_total_r;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (total_r == $past(total_r)) || (total_r == $past(total_r) + CNT_W'(1)) ||
             (total_r == $past(total_r) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_sum_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept && op == vot_pkg::OP_SUM |=> state_r == vot_pkg::S_SCAN && !out_valid_r)
    else $error("sum did not start a scan");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept) || $past(state_r == vot_pkg::S_DONE))
    else $error("result appeared without a transaction");

  a_total_stable_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != vot_pkg::S_IDLE |=> $stable(total_r))
    else $error("entry count changed during a sum");

endmodule
